// ----- hw/rtl/fcsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the serial frame checker.
// No dependencies.
package fcsc_pkg;

  localparam logic [7:0] HEADER_BYTE    = 8'hEA;
  localparam logic [7:0] TRAILER_FIRST  = 8'hED;
  localparam logic [7:0] TRAILER_SECOND = 8'hEE;

  localparam int unsigned POS_W = 3;
  localparam int unsigned HIST_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX       = 3'd7;
  localparam logic [POS_W-1:0] CMD_POS       = 3'd2;
  localparam logic [POS_W-1:0] MIN_LAST_POS  = 3'd5;
  localparam logic [POS_W-1:0] SUM_START_POS = 3'd6;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HEADER  = 3'd1,
    ST_BAD_TRAILER = 3'd2,
    ST_BAD_SUM     = 3'd3,
    ST_TOO_SHORT   = 3'd4
  } status_t;

endpackage

// ----- hw/rtl/frame_checker_sum_checksum.sv -----
`timescale 1ns / 1ps
// Serial frame checker: length/header/trailer/checksum check with one result per frame.
// Depends on fcsc_pkg.
//
// Takes one frame byte per cycle when not stalled. A request is held in the input
// register and, for a last byte, its result goes to the output register. Each byte is
// captured in an input register and then folded into the frame state (position,
// header flag, command, running sum, four-byte history) by a single adder and a
// few compares. The input stalls only while a last byte finds the result
// register still holding an untaken result.
module frame_checker_sum_checksum (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_cmd_code,
  output logic [7:0] out_computed_sum
);
  import fcsc_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_r, hdr_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       hist_r   [HIST_DEPTH];
  logic [7:0]       hist_nxt [HIST_DEPTH];

  // result register
  logic       out_valid_r;
  status_t    status_r, status_nxt;
  logic [7:0] cmd_out_r;
  logic [7:0] sum_out_r, sum_out_nxt;

  logic       out_free;
  logic       s1_go;
  logic [7:0] rx_check;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    hdr_nxt = hdr_r;
    if ((pos_r == '0 || pos_r == 3'd1) && s1_byte_r != HEADER_BYTE) begin
      hdr_nxt = 1'b0;
    end
    cmd_nxt = (pos_r == CMD_POS) ? s1_byte_r : cmd_r;
    sum_nxt = (pos_r >= SUM_START_POS) ? sum_r + hist_r[3] : sum_r;
    hist_nxt[0] = s1_byte_r;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
    pos_nxt = (pos_r < POS_MAX) ? pos_r + 3'd1 : pos_r;

    rx_check = {hist_nxt[3][3:0], hist_nxt[2][3:0]};
    if (pos_r < MIN_LAST_POS) begin
      status_nxt = ST_TOO_SHORT;
    end else if (!hdr_nxt) begin
      status_nxt = ST_BAD_HEADER;
    end else if (hist_nxt[1] != TRAILER_FIRST || hist_nxt[0] != TRAILER_SECOND) begin
      status_nxt = ST_BAD_TRAILER;
    end else if (sum_nxt != rx_check) begin
      status_nxt = ST_BAD_SUM;
    end else begin
      status_nxt = ST_OK;
    end
    sum_out_nxt = (pos_r < MIN_LAST_POS) ? 8'h00 : sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      hdr_r       <= 1'b1;
      cmd_r       <= '0;
      sum_r       <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last_r) begin
          out_valid_r <= 1'b1;
          pos_r       <= '0;
          hdr_r       <= 1'b1;
          cmd_r       <= '0;
          sum_r       <= '0;
          for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_r[i] <= '0;
          end
        end else begin
          pos_r <= pos_nxt;
          hdr_r <= hdr_nxt;
          cmd_r <= cmd_nxt;
          sum_r <= sum_nxt;
          for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_r[i] <= hist_nxt[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_go && s1_last_r) begin
      status_r  <= status_nxt;
      cmd_out_r <= cmd_nxt;
      sum_out_r <= sum_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_cmd_code     = cmd_out_r;
  assign out_computed_sum = sum_out_r;

endmodule

// ----- hw/rtl/fcsc_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the frame checker, bound to its top level.
// Depends on fcsc_pkg and frame_checker_sum_checksum.
module fcsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_data_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [7:0] out_cmd_code,
  input logic [7:0] out_computed_sum
);
  import fcsc_pkg::*;

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) &&
      $stable(in_last_byte))
    else $error("request changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_cmd_code) && $stable(out_computed_sum))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_HEADER ||
      out_status == ST_BAD_TRAILER || out_status == ST_BAD_SUM ||
      out_status == ST_TOO_SHORT))
    else $error("status code out of range");

  a_short_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_SHORT |-> out_computed_sum == 8'h00)
    else $error("short frame reports nonzero sum");

  // a result only rises after a taken last-byte request has passed the input register
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))
    else $error("result without a last byte");

endmodule

bind frame_checker_sum_checksum fcsc_checker u_fcsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_data_byte     (in_data_byte),
  .in_last_byte     (in_last_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_cmd_code     (out_cmd_code),
  .out_computed_sum (out_computed_sum)
);
